FILE: rtl/core/asv_pkg.sv
// ----------------------------------------------------------------------------
// asv_pkg
// Shared types, codes and the pitch table of the sawtooth synthesizer voice.
// ----------------------------------------------------------------------------
package asv_pkg;

  // Envelope fixed point: unsigned Q1.23, full scale 1.0 = 2^23
  localparam int ENV_FRAC_BITS = 23;
  localparam int LEVEL_W       = 24;
  localparam int PHASE_W       = 32;
  localparam int CFG_INDEX_W   = 2;
  localparam logic [LEVEL_W-1:0] ENV_ONE = LEVEL_W'(1) << ENV_FRAC_BITS;

  // Transaction opcodes
  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_PRESS   = 2'd1,
    OP_RELEASE = 2'd2
  } opcode_t;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ATTACK_STEP   = 2'd0,
    REG_DECAY_STEP    = 2'd1,
    REG_SUSTAIN_LEVEL = 2'd2,
    REG_RELEASE_STEP  = 2'd3
  } cfg_reg_t;

  // Input transaction
  typedef struct packed {
    logic [1:0] opcode;
    logic [3:0] note;
    logic [3:0] octave;
    logic [3:0] volume;
  } item_t;

  // Result transaction
  typedef struct packed {
    logic [7:0]         sample;
    logic [LEVEL_W-1:0] level;
  } result_t;

  // Tick handed from the state stage to the sample stage
  typedef struct packed {
    logic [7:0]         top_byte;
    logic [LEVEL_W-1:0] level;
    logic [3:0]         volume;
  } tick_t;

  // Octave-4 phase steps, C through B
  localparam logic [PHASE_W-1:0] PITCH_TABLE [12] = '{
    32'd51076056, 32'd54113197, 32'd57330935, 32'd60740009,
    32'd64351798, 32'd68178356, 32'd72232452, 32'd76527617,
    32'd81078186, 32'd85899345, 32'd91007186, 32'd96418755
  };

  // Phase step for a note and octave; notes above B act as B
  function automatic logic [PHASE_W-1:0] pitch_step(input logic [3:0] note,
                                                    input logic [3:0] octave);
    logic [3:0]         idx;
    logic [PHASE_W-1:0] s;
    idx = (note > 4'd11) ? 4'd11 : note;
    s   = PITCH_TABLE[idx];
    if (octave > 4'd4) begin
      s = s << (octave - 4'd4);
    end else if (octave < 4'd4) begin
      s = s >> (4'd4 - octave);
    end
    return s;
  endfunction

endpackage

FILE: rtl/core/asv_item_if.sv
// ----------------------------------------------------------------------------
// asv_item_if
// Valid/ready channel carrying input transactions of the voice.
// ----------------------------------------------------------------------------
interface asv_item_if import asv_pkg::*; ();
  logic  valid;
  logic  ready;
  item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/core/asv_result_if.sv
// ----------------------------------------------------------------------------
// asv_result_if
// Valid/ready channel carrying result transactions of the voice.
// ----------------------------------------------------------------------------
interface asv_result_if import asv_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/core/asv_voice_state.sv
// ----------------------------------------------------------------------------
// asv_voice_state
// Configuration registers, envelope and phase state; steps the voice once
// per transaction and hands ticks on to the sample stage.
// ----------------------------------------------------------------------------
module asv_voice_state import asv_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [LEVEL_W-1:0]     cfg_data,
  input  logic                   item_valid,
  input  item_t                  item_q,
  output logic                   item_ready,
  output logic                   mid_valid,
  output tick_t                  mid,
  input  logic                   mid_ready
);

  logic [LEVEL_W-1:0] attack_step, decay_step, sustain_level, release_step;
  logic [PHASE_W-1:0] phase, phase_next;
  logic [LEVEL_W-1:0] envelope, envelope_next;
  logic [PHASE_W-1:0] step_size, step_size_next;
  logic               held, held_next;
  logic               releasing, releasing_next;
  logic               fire, is_tick;
  logic [LEVEL_W:0]   attack_sum, decay_diff;

  assign item_ready = !mid_valid || mid_ready;
  assign fire       = item_valid && item_ready;
  assign is_tick    = item_q.opcode == OP_TICK;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      attack_step   <= LEVEL_W'(839);
      decay_step    <= LEVEL_W'(8389);
      sustain_level <= LEVEL_W'(5033165);
      release_step  <= LEVEL_W'(419);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ATTACK_STEP:   attack_step   <= cfg_data;
        REG_DECAY_STEP:    decay_step    <= cfg_data;
        REG_SUSTAIN_LEVEL: sustain_level <= cfg_data;
        REG_RELEASE_STEP:  release_step  <= cfg_data;
        default:           ;
      endcase
    end
  end

  assign attack_sum = {1'b0, envelope} + {1'b0, attack_step};
  assign decay_diff = {1'b0, envelope} - {1'b0, decay_step};

  // Step the envelope and phase for one transaction
  always_comb begin
    phase_next     = phase;
    envelope_next  = envelope;
    step_size_next = step_size;
    held_next      = held;
    releasing_next = releasing;
    case (item_q.opcode)
      OP_PRESS: begin
        step_size_next = pitch_step(item_q.note, item_q.octave);
        held_next      = 1'b1;
        releasing_next = 1'b0;
      end
      OP_RELEASE: begin
        held_next      = 1'b0;
        releasing_next = 1'b1;
      end
      OP_TICK: begin
        if (held) begin
          if (envelope < ENV_ONE) begin
            envelope_next = (attack_sum > {1'b0, ENV_ONE}) ? ENV_ONE
                                                           : attack_sum[LEVEL_W-1:0];
          end else if (envelope > sustain_level) begin
            // Clamp at sustain, including when the step goes below zero
            envelope_next = (decay_diff[LEVEL_W] ||
                             decay_diff[LEVEL_W-1:0] < sustain_level)
                            ? sustain_level : decay_diff[LEVEL_W-1:0];
          end
        end else if (releasing) begin
          if (envelope <= release_step) begin
            envelope_next  = '0;
            releasing_next = 1'b0;
          end else begin
            envelope_next = envelope - release_step;
          end
        end else begin
          step_size_next = '0;
        end
        // Advance with the step loaded before this tick
        if (envelope_next != '0) begin
          phase_next = phase + step_size;
        end
      end
      default: ;
    endcase
  end

  // Hold voice state between transactions
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= '0;
      envelope  <= '0;
      step_size <= '0;
      held      <= 1'b0;
      releasing <= 1'b0;
    end else if (fire) begin
      phase     <= phase_next;
      envelope  <= envelope_next;
      step_size <= step_size_next;
      held      <= held_next;
      releasing <= releasing_next;
    end
  end

  // Pass ticks to the sample stage
  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
    end else if (item_ready) begin
      mid_valid <= fire && is_tick;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && is_tick) begin
      mid.top_byte <= phase_next[PHASE_W-1 -: 8];
      mid.level    <= envelope_next;
      mid.volume   <= item_q.volume;
    end
  end

  a_env_bound: assert property (@(posedge clk) disable iff (rst)
    envelope <= ENV_ONE)
    else $error("envelope above full scale");

  a_gate_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(held && releasing))
    else $error("held and releasing both set");

  a_phase_only_on_tick: assert property (@(posedge clk) disable iff (rst)
    !(fire && is_tick) |=> $stable(phase))
    else $error("phase moved without a tick");

endmodule

FILE: rtl/core/asv_sample_out.sv
// ----------------------------------------------------------------------------
// asv_sample_out
// Scales the sawtooth by the envelope and volume and holds the result
// transaction until the receiver takes it.
// ----------------------------------------------------------------------------
module asv_sample_out import asv_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          mid_valid,
  input  tick_t         mid,
  output logic          mid_ready,
  asv_result_if.source  result
);

  logic                       neg;
  logic [7:0]                 mag;
  logic [8+LEVEL_W-1:0]       prod;
  logic [7:0]                 scaled;
  logic signed [8:0]          signed_v, shifted_v;
  logic [3:0]                 sh;
  logic [7:0]                 sample_next;

  assign mid_ready = !result.valid || result.ready;

  // Sign and magnitude of the top phase byte minus 128
  assign neg = !mid.top_byte[7];
  assign mag = neg ? (8'd128 - mid.top_byte) : (mid.top_byte - 8'd128);

  // Scale by the level, truncating toward zero, then floor-shift by volume
  assign prod      = {{LEVEL_W{1'b0}}, mag} * {8'b0, mid.level};
  assign scaled    = prod[ENV_FRAC_BITS +: 8];
  assign signed_v  = neg ? -$signed({1'b0, scaled}) : $signed({1'b0, scaled});
  assign sh        = (mid.volume > 4'd8) ? 4'd0 : (4'd8 - mid.volume);
  assign shifted_v = signed_v >>> sh;
  assign sample_next = shifted_v[7:0] + 8'd128;

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (mid_ready) begin
      result.valid <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_valid && mid_ready) begin
      result.payload.sample <= sample_next;
      result.payload.level  <= mid.level;
    end
  end

endmodule

FILE: rtl/core/adsr_sawtooth_voice.sv
// ----------------------------------------------------------------------------
// adsr_sawtooth_voice
// One synthesizer voice: sawtooth phase accumulator shaped by an ADSR
// envelope.
// ----------------------------------------------------------------------------
// Usage:
//   item   - valid/ready input channel. Opcode tick steps the envelope and
//            phase and yields one result; press loads the pitch step and
//            starts attack; release starts release. Press, release and the
//            unused opcode yield no result.
//   result - valid/ready output channel: 8-bit sample centered at 128 and
//            the Q1.23 envelope level after the tick.
//   cfg_we/cfg_index/cfg_data - register writes, taken on any edge with
//            cfg_we high; write only while the voice is idle.
// Path: a tick passes the input register, the state stage and the result register.
// Throughput: one transaction per cycle when not stalled; the voice state
//   (phase, envelope, step) updates as each is taken, so each tick follows
//   the previous one directly, and the multiply sits in its own stage behind it.
// Reset: envelope, phase and step clear, the gate is off, the registers
//   return to their defaults and both channels empty.
// Stall: a held result blocks the sample stage, then the state stage, then
//   the input register; nothing is dropped.
// ----------------------------------------------------------------------------
module adsr_sawtooth_voice import asv_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [LEVEL_W-1:0]     cfg_data,
  asv_item_if.sink               item,
  asv_result_if.source           result
);

  logic  item_valid, item_ready;
  item_t item_q;
  logic  mid_valid, mid_ready;
  tick_t mid;

  assign item.ready = !item_valid || item_ready;

  // Register the incoming transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (item.ready) begin
      item_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      item_q <= item.payload;
    end
  end

  asv_voice_state u_state (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item_q     (item_q),
    .item_ready (item_ready),
    .mid_valid  (mid_valid),
    .mid        (mid),
    .mid_ready  (mid_ready)
  );

  asv_sample_out u_sample (
    .clk       (clk),
    .rst       (rst),
    .mid_valid (mid_valid),
    .mid       (mid),
    .mid_ready (mid_ready),
    .result    (result)
  );

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.payload.level <= ENV_ONE)
    else $error("result level above full scale");

endmodule
